/* hdl/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, codes and controller/datapath types of the block pool.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Payload field widths.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned BLK_W    = 8;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned BYTES_W  = 13;
  localparam int unsigned OFFS_W   = 20;
  localparam int unsigned CTR_W    = 32;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // One stored link: valid flag over a block index.
  localparam int unsigned LINK_W = CNT_W + 1;

  // Register values after reset.
  localparam int unsigned CNT_RESET   = 256;
  localparam int unsigned BYTES_RESET = 32;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // latch the incoming transaction, issue the link read
    logic sweep_step;  // write one implicit link
    logic commit;      // apply the item and load the result register
  } fbpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_sweep; // incoming free lies below the boundary with a gap
    logic sweep_last;  // current sweep write is the final one
    logic out_free;    // result register can take a new result
  } fbpa_sts_t;

endpackage

/* hdl/fbpa_if.sv */
// ----------------------------------------------------------------------------
// fbpa_if
// Valid/ready channels of the block pool: request, response and register write.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
  logic                        valid;
  logic                        ready;
  logic [fbpa_pkg::MODE_W-1:0] mode;
  logic [fbpa_pkg::BLK_W-1:0]  block_index;
  logic                        pointer_present;

  modport source (output valid, mode, block_index, pointer_present, input ready);
  modport sink   (input valid, mode, block_index, pointer_present, output ready);
endinterface

interface fbpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         grant_ok;
  logic [fbpa_pkg::BLK_W-1:0]   granted_index;
  logic [fbpa_pkg::OFFS_W-1:0]  byte_offset;
  logic [fbpa_pkg::CNT_W-1:0]   free_blocks;
  logic [fbpa_pkg::CTR_W-1:0]   total_allocs;
  logic [fbpa_pkg::CTR_W-1:0]   total_fails;

  modport source (output valid, grant_ok, granted_index, byte_offset, free_blocks,
                  total_allocs, total_fails, input ready);
  modport sink   (input valid, grant_ok, granted_index, byte_offset, free_blocks,
                  total_allocs, total_fails, output ready);
endinterface

interface fbpa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fbpa_pkg::CFG_IDX_W-1:0]  index;
  logic [fbpa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/fbpa_ram.sv */
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage write and registered read; read data holds while re_i is low.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/fbpa_ctrl.sv */
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer of the block pool: accept, link sweep and commit of one item.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fbpa_pkg::fbpa_sts_t sts_i,
  output fbpa_pkg::fbpa_cmd_t cmd_o
);
  import fbpa_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    cmd_o.accept     = 1'b0;
    cmd_o.sweep_step = 1'b0;
    cmd_o.commit     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.needs_sweep ? ST_SWEEP : ST_COMMIT;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/fbpa_dp.sv */
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath of the block pool: registers, list state, link RAM and result.
// ----------------------------------------------------------------------------
module fbpa_dp #(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fbpa_pkg::fbpa_cmd_t                  cmd_i,
  output fbpa_pkg::fbpa_sts_t                  sts_o,
  // Request payload.
  input  logic [fbpa_pkg::MODE_W-1:0]          mode_i,
  input  logic [fbpa_pkg::BLK_W-1:0]           block_index_i,
  input  logic                                 pointer_present_i,
  // Register writes.
  input  logic                                 cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 grant_ok_o,
  output logic [fbpa_pkg::BLK_W-1:0]           granted_index_o,
  output logic [fbpa_pkg::OFFS_W-1:0]          byte_offset_o,
  output logic [fbpa_pkg::CNT_W-1:0]           free_blocks_o,
  output logic [fbpa_pkg::CTR_W-1:0]           total_allocs_o,
  output logic [fbpa_pkg::CTR_W-1:0]           total_fails_o
);
  import fbpa_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_BLOCKS);
  localparam int unsigned RST_N  = (CNT_RESET > MAX_BLOCKS) ? MAX_BLOCKS : CNT_RESET;
  localparam logic [CNT_W-1:0] RST_CNT = CNT_W'(RST_N);

  // Configuration registers.
  logic [CNT_W-1:0]   cnt_q;
  logic [BYTES_W-1:0] bytes_q;

  // List state.
  logic [CNT_W-1:0] head_q, head_d;
  logic             head_ok_q, head_ok_d;
  logic [CNT_W-1:0] bnd_q, bnd_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CTR_W-1:0] allocs_q, allocs_d;
  logic [CTR_W-1:0] fails_q, fails_d;

  // Latched item and sweep pointer.
  logic [MODE_W-1:0] mode_q;
  logic [BLK_W-1:0]  blk_q;
  logic              present_q;
  logic [CNT_W-1:0]  ptr_q;

  // Result register.
  logic              out_valid_q;
  logic              grant_q, grant_d;
  logic [CNT_W-1:0]  gidx_q, gidx_d;
  logic [OFFS_W-1:0] offs_q;

  logic [CNT_W-1:0]  n_eff;
  logic [LINK_W-1:0] rdata;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic              ram_re;
  logic              free_hit;
  logic [CNT_W+BYTES_W-1:0] prod;

  // Block count in effect: zero acts as one, values past the pool size are capped.
  always_comb begin
    if (cnt_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(cnt_q) > 32'(MAX_BLOCKS)) begin
      n_eff = CNT_W'(MAX_BLOCKS);
    end else begin
      n_eff = cnt_q;
    end
  end

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= CNT_W'(CNT_RESET);
      bytes_q <= BYTES_W'(BYTES_RESET);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BLOCK_COUNT: cnt_q   <= cfg_data_i[CNT_W-1:0];
        REG_BLOCK_BYTES: bytes_q <= cfg_data_i[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Status toward the controller.
  assign sts_o.needs_sweep = (mode_i == MODE_FREE) && pointer_present_i &&
                             ({1'b0, block_index_i} < n_eff) &&
                             ({1'b0, block_index_i} + CNT_W'(1) < bnd_q);
  assign sts_o.sweep_last  = ({1'b0, ptr_q} + (CNT_W+1)'(1)) >= {1'b0, bnd_q};
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  // A free that really pushes a block.
  assign free_hit = (mode_q == MODE_FREE) && present_q && ({1'b0, blk_q} < n_eff);

  // Link RAM ports: read the head link on an allocate, write sweep or push links.
  assign ram_re = cmd_i.accept && (mode_i == MODE_ALLOC);
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(ptr_q);
    ram_wdata = {1'b1, ptr_q - CNT_W'(1)};
    if (cmd_i.sweep_step) begin
      ram_we = 1'b1;
    end else if (cmd_i.commit && free_hit) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(blk_q);
      ram_wdata = {head_ok_q, head_q};
    end
  end

  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ADDR_W'(head_q)),
    .rdata_o (rdata)
  );

  // Item latch and sweep pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q    <= mode_i;
      blk_q     <= block_index_i;
      present_q <= pointer_present_i;
      ptr_q     <= {1'b0, block_index_i} + CNT_W'(1);
    end else if (cmd_i.sweep_step) begin
      ptr_q <= ptr_q + CNT_W'(1);
    end
  end

  // Effect of the item on the list state.
  always_comb begin
    head_d    = head_q;
    head_ok_d = head_ok_q;
    bnd_d     = bnd_q;
    free_d    = free_q;
    allocs_d  = allocs_q;
    fails_d   = fails_q;
    grant_d   = 1'b0;
    gidx_d    = '0;
    case (mode_q)
      MODE_INIT: begin
        head_d    = n_eff - CNT_W'(1);
        head_ok_d = 1'b1;
        bnd_d     = n_eff;
        free_d    = n_eff;
        allocs_d  = '0;
        fails_d   = '0;
      end
      MODE_ALLOC: begin
        if (head_ok_q) begin
          grant_d = 1'b1;
          gidx_d  = head_q;
          if (head_q < bnd_q) begin
            // Below the boundary the link is implicit.
            head_d    = head_q - CNT_W'(1);
            head_ok_d = (head_q != '0);
            bnd_d     = head_q;
          end else begin
            head_d    = rdata[CNT_W-1:0];
            head_ok_d = rdata[CNT_W];
          end
          if (free_q != '0) begin
            free_d = free_q - CNT_W'(1);
          end
          allocs_d = allocs_q + CTR_W'(1);
        end else begin
          fails_d = fails_q + CTR_W'(1);
        end
      end
      MODE_FREE: begin
        if (free_hit) begin
          if ({1'b0, blk_q} < bnd_q) begin
            bnd_d = {1'b0, blk_q};
          end
          head_d    = {1'b0, blk_q};
          head_ok_d = 1'b1;
          if (free_q < n_eff) begin
            free_d = free_q + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
    // The count never exceeds the block count in effect.
    if (free_d > n_eff) begin
      free_d = n_eff;
    end
  end

  // List state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= RST_CNT - CNT_W'(1);
      head_ok_q <= 1'b1;
      bnd_q     <= RST_CNT;
      free_q    <= RST_CNT;
      allocs_q  <= '0;
      fails_q   <= '0;
    end else if (cmd_i.commit) begin
      head_q    <= head_d;
      head_ok_q <= head_ok_d;
      bnd_q     <= bnd_d;
      free_q    <= free_d;
      allocs_q  <= allocs_d;
      fails_q   <= fails_d;
    end
  end

  // Byte offset of the granted block.
  assign prod = gidx_d * bytes_q;

  // Result register and its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      grant_q <= grant_d;
      gidx_q  <= gidx_d;
      offs_q  <= prod[OFFS_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign grant_ok_o      = grant_q;
  assign granted_index_o = gidx_q[BLK_W-1:0];
  assign byte_offset_o   = offs_q;
  assign free_blocks_o   = free_q;
  assign total_allocs_o  = allocs_q;
  assign total_fails_o   = fails_q;

endmodule

/* hdl/fixed_block_pool_allocator.sv */
// A result is registered when its item commits, after acceptance and any link sweep;
// the commit waits while the result register is still full. No new request is taken
// until the current item has committed. A free below the untouched boundary first
// sweeps, writing the implicit link of each block between it and the boundary.
// Reset: asynchronous, active low; registers take their defaults, the pool is
// initialized at once and the link RAM is not cleared.
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with a last-in-first-out free list of linked blocks.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbpa_req_if.sink   req_if,
  fbpa_rsp_if.source rsp_if,
  fbpa_cfg_if.sink   cfg_if
);
  import fbpa_pkg::*;

  fbpa_cmd_t cmd;
  fbpa_sts_t sts;
  logic      in_ready;

  // Register writes are always taken.
  assign cfg_if.ready = 1'b1;
  assign req_if.ready = in_ready;

  fbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .mode_i            (req_if.mode),
    .block_index_i     (req_if.block_index),
    .pointer_present_i (req_if.pointer_present),
    .cfg_we_i          (cfg_if.valid),
    .cfg_index_i       (cfg_if.index),
    .cfg_data_i        (cfg_if.data),
    .out_valid_o       (rsp_if.valid),
    .out_ready_i       (rsp_if.ready),
    .grant_ok_o        (rsp_if.grant_ok),
    .granted_index_o   (rsp_if.granted_index),
    .byte_offset_o     (rsp_if.byte_offset),
    .free_blocks_o     (rsp_if.free_blocks),
    .total_allocs_o    (rsp_if.total_allocs),
    .total_fails_o     (rsp_if.total_fails)
  );

endmodule
